// ===== rtl/ndsc_pkg.sv =====
`default_nettype none
package ndsc_pkg;

    localparam int HASH_W = 57;
    localparam logic [HASH_W-1:0] HASH_MOD = 57'd98120979115476319;
    localparam logic [6:0] HASH_BASE = 7'd94;
    localparam logic [6:0] CHAR_OFFSET = 7'd33;
    localparam int IDX_W = 10;
    localparam int COL_W = 6;
    localparam logic [10:0] MAX_STRINGS = 11'd1024;
    localparam logic [6:0] MAX_LENGTH = 7'd64;
    localparam logic [18:0] COUNT_MAX = 19'd524287;

    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_H_RD,
        S_H_GO,
        S_H_MUL,
        S_P_RD,
        S_P_CMP,
        S_P_END,
        S_K_RD,
        S_K_GO,
        S_K_MUL,
        S_W_GO,
        S_W_MUL,
        S_FIN
    } state_t;

    // result = (a * m + b) mod HASH_MOD
    typedef struct packed {
        logic [HASH_W-1:0] a;
        logic [6:0]        m;
        logic [HASH_W-1:0] b;
    } mm_req_t;

    // digit (c - 33) reduced into 0..HASH_MOD-1
    function automatic logic [HASH_W-1:0] digit_mod(input logic [6:0] c);
        logic [HASH_W-1:0] r;
        if (c >= CHAR_OFFSET)
        begin
            r = {{(HASH_W-7){1'b0}}, c - CHAR_OFFSET};
        end
        else
        begin
            r = HASH_MOD - {{(HASH_W-7){1'b0}}, CHAR_OFFSET - c};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ndsc_mulmod.sv =====
`default_nettype none
module ndsc_mulmod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire ndsc_pkg::mm_req_t          req,
    output logic                            done,
    output logic [ndsc_pkg::HASH_W-1:0]     result
);
    import ndsc_pkg::*;

    // MSB-first double-and-add: even step doubles, odd step adds a if the bit is set,
    // step 14 adds b. One modular add per cycle.
    logic              busy_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [HASH_W-1:0] acc_reg;
    mm_req_t           req_reg;

    logic [HASH_W-1:0] operand;
    logic [HASH_W:0]   sum;
    logic [HASH_W:0]   diff;
    logic [HASH_W-1:0] red;
    logic [2:0]        bit_sel;

    always_comb
    begin
        bit_sel = 3'd6 - cnt_reg[3:1];
        if (cnt_reg == 4'd14)
        begin
            operand = req_reg.b;
        end
        else if (cnt_reg[0])
        begin
            operand = req_reg.m[bit_sel] ? req_reg.a : '0;
        end
        else
        begin
            operand = acc_reg;
        end
        sum  = {1'b0, acc_reg} + {1'b0, operand};
        diff = sum - {1'b0, HASH_MOD};
        red  = (sum >= {1'b0, HASH_MOD}) ? diff[HASH_W-1:0] : sum[HASH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd14)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= req;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= red;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/near_duplicate_string_counter_unit.sv =====
`default_nettype none
// Near-duplicate string counter.
// Input stream (s_*): one character per request, string_count strings of
// string_length characters sent back to back. Characters are taken one per
// cycle while the block is loading.
// After the final character the block stops taking requests and computes:
//   hashes: n*len Horner steps (modular multiply unit),
//   identical pairs: all-pairs sweep, a read and a compare state per pair,
//   per position (len times): n key updates, one pair sweep and one power update.
// The compute time is set by the single serial mod-multiply unit and the
// two-port key memory.
// Output stream (m_*): one request per data set, held in an output register
// until taken; loading of the next set proceeds meanwhile, and the block waits
// only if a new result is ready while the previous one still stands.
// APB port: string_count at 0x0, string_length at 0x4, report_mode at 0x8.
// A write restarts loading at the first character of the first string.
// Reset: registers return to 2 / 8 / 0, loading starts over, output is empty.
// Stores (characters, hashes, keys) are not cleared; they are always written
// before being read within a data set.
module near_duplicate_string_counter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [6:0] character
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [0] found, [10:1] pair_first,
                                        // [20:11] pair_second, [39:21] similar_count
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ndsc_pkg::*;

    state_t state_reg, state_next;

    logic [10:0] cnt_cfg_reg;
    logic [6:0]  len_cfg_reg;
    logic        mode_reg;

    logic [10:0]      neff;
    logic [6:0]       leff;
    logic [IDX_W-1:0] nm1;
    logic [COL_W-1:0] lm1;

    logic [IDX_W-1:0] s_reg;
    logic [COL_W-1:0] p_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] i_reg;
    logic [COL_W-1:0] col_reg;
    logic [HASH_W-1:0] h_reg;
    logic [HASH_W-1:0] w_reg;
    logic              rec_reg;
    logic [18:0]       pair_cnt_reg;
    logic [18:0]       ident_reg;
    logic [25:0]       total_reg;
    logic [IDX_W-1:0]  last_lo_reg;
    logic [IDX_W-1:0]  last_hi_reg;
    logic              pb_valid_reg;
    logic [HASH_W-1:0] pb_key_reg;
    logic [IDX_W-1:0]  pb_i_reg;
    logic [IDX_W-1:0]  pb_j_reg;
    logic              out_valid_reg;
    logic [39:0]       out_data_reg;

    // memories
    logic [6:0]        char_mem [0:65535];
    logic [HASH_W-1:0] hash_mem [0:1023];
    logic [HASH_W-1:0] key_mem  [0:1023];
    logic [6:0]        char_rd;
    logic [HASH_W-1:0] hash_rd;
    logic [HASH_W-1:0] key_rd_a;
    logic [HASH_W-1:0] key_rd_b;
    logic              key_we;

    // shared unit
    mm_req_t           mm_req;
    logic              mm_start;
    logic              mm_done;
    logic [HASH_W-1:0] mm_res;

    logic cfg_wr;
    logic in_acc;
    logic last_char;
    logic last_j;
    logic sweep_done;
    logic key_eq;
    logic better;

    logic [24:0] sub;
    logic [25:0] diff;
    logic [18:0] sim;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_COUNT:  prdata = {21'd0, cnt_cfg_reg};
            REG_LENGTH: prdata = {25'd0, len_cfg_reg};
            REG_MODE:   prdata = {31'd0, mode_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        if (cnt_cfg_reg == 11'd0)
        begin
            neff = 11'd1;
        end
        else if (cnt_cfg_reg > MAX_STRINGS)
        begin
            neff = MAX_STRINGS;
        end
        else
        begin
            neff = cnt_cfg_reg;
        end
        if (len_cfg_reg == 7'd0)
        begin
            leff = 7'd1;
        end
        else if (len_cfg_reg > MAX_LENGTH)
        begin
            leff = MAX_LENGTH;
        end
        else
        begin
            leff = len_cfg_reg;
        end
    end

    assign nm1 = IDX_W'(neff - 11'd1);
    assign lm1 = COL_W'(leff - 7'd1);

    assign s_tready  = (state_reg == S_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign last_char = (s_reg == nm1) && (p_reg == lm1);
    assign last_j    = (idx_reg == nm1);
    assign sweep_done = last_j && (i_reg == nm1 - IDX_W'(1));
    assign key_eq    = (key_rd_a == key_rd_b);
    assign better    = !pb_valid_reg || (key_rd_a > pb_key_reg) ||
                       ((key_rd_a == pb_key_reg) && ((idx_reg > pb_j_reg) ||
                       ((idx_reg == pb_j_reg) && (i_reg > pb_i_reg))));

    // unit requests
    always_comb
    begin
        mm_start = 1'b0;
        mm_req   = '0;
        unique case (state_reg)
            S_H_GO:
            begin
                mm_start = 1'b1;
                mm_req.a = h_reg;
                mm_req.m = HASH_BASE;
                mm_req.b = digit_mod(char_rd);
            end
            S_K_GO:
            begin
                mm_start = 1'b1;
                // subtract d*w: add |d|*(P-w) for d >= 0, |d|*w for d < 0
                mm_req.a = (char_rd >= CHAR_OFFSET) ? (HASH_MOD - w_reg) : w_reg;
                mm_req.m = (char_rd >= CHAR_OFFSET) ? (char_rd - CHAR_OFFSET)
                                                    : (CHAR_OFFSET - char_rd);
                mm_req.b = hash_rd;
            end
            S_W_GO:
            begin
                mm_start = 1'b1;
                mm_req.a = w_reg;
                mm_req.m = HASH_BASE;
                mm_req.b = '0;
            end
            default:
            begin
                mm_start = 1'b0;
            end
        endcase
    end

    ndsc_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .req    (mm_req),
        .done   (mm_done),
        .result (mm_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && last_char)
                begin
                    state_next = S_H_RD;
                end
            end
            S_H_RD:  state_next = S_H_GO;
            S_H_GO:  state_next = S_H_MUL;
            S_H_MUL:
            begin
                if (mm_done)
                begin
                    if ((col_reg == lm1) && last_j)
                    begin
                        state_next = (nm1 == '0) ? S_P_END : S_P_RD;
                    end
                    else
                    begin
                        state_next = S_H_RD;
                    end
                end
            end
            S_P_RD:  state_next = S_P_CMP;
            S_P_CMP: state_next = sweep_done ? S_P_END : S_P_RD;
            S_P_END: state_next = rec_reg ? S_W_GO : S_K_RD;
            S_K_RD:  state_next = S_K_GO;
            S_K_GO:  state_next = S_K_MUL;
            S_K_MUL:
            begin
                if (mm_done)
                begin
                    if (last_j)
                    begin
                        state_next = (nm1 == '0) ? S_P_END : S_P_RD;
                    end
                    else
                    begin
                        state_next = S_K_RD;
                    end
                end
            end
            S_W_GO:  state_next = S_W_MUL;
            S_W_MUL:
            begin
                if (mm_done)
                begin
                    state_next = (col_reg == '0) ? S_FIN : S_K_RD;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // result formatting
    always_comb
    begin
        sub  = ident_reg * lm1;
        diff = (total_reg > {1'b0, sub}) ? (total_reg - {1'b0, sub}) : 26'd0;
        sim  = (diff > {7'd0, COUNT_MAX}) ? COUNT_MAX : diff[18:0];
    end

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_cfg_reg   <= 11'd2;
            len_cfg_reg   <= 7'd8;
            mode_reg      <= 1'b0;
            s_reg         <= '0;
            p_reg         <= '0;
            idx_reg       <= '0;
            i_reg         <= '0;
            col_reg       <= '0;
            rec_reg       <= 1'b0;
            pair_cnt_reg  <= '0;
            ident_reg     <= '0;
            total_reg     <= '0;
            last_lo_reg   <= '0;
            last_hi_reg   <= '0;
            pb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_COUNT:  cnt_cfg_reg <= pwdata[10:0];
                    REG_LENGTH: len_cfg_reg <= pwdata[6:0];
                    REG_MODE:   mode_reg    <= pwdata[0];
                    default:    ;
                endcase
                if (paddr[3:2] inside {REG_COUNT, REG_LENGTH, REG_MODE})
                begin
                    s_reg <= '0;
                    p_reg <= '0;
                end
            end

            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (p_reg == lm1)
                        begin
                            p_reg <= '0;
                            s_reg <= (s_reg == nm1) ? '0 : s_reg + IDX_W'(1);
                        end
                        else
                        begin
                            p_reg <= p_reg + COL_W'(1);
                        end
                        if (last_char)
                        begin
                            idx_reg <= '0;
                            col_reg <= '0;
                        end
                    end
                end
                S_H_MUL:
                begin
                    if (mm_done)
                    begin
                        if (col_reg == lm1)
                        begin
                            col_reg <= '0;
                            if (last_j)
                            begin
                                rec_reg      <= 1'b0;
                                i_reg        <= '0;
                                idx_reg      <= IDX_W'(1);
                                pair_cnt_reg <= '0;
                                pb_valid_reg <= 1'b0;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + COL_W'(1);
                        end
                    end
                end
                S_P_CMP:
                begin
                    if (key_eq)
                    begin
                        pair_cnt_reg <= pair_cnt_reg + 19'd1;
                        if (rec_reg && better)
                        begin
                            pb_valid_reg <= 1'b1;
                        end
                    end
                    if (last_j)
                    begin
                        i_reg   <= i_reg + IDX_W'(1);
                        idx_reg <= i_reg + IDX_W'(2);
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_P_END:
                begin
                    if (!rec_reg)
                    begin
                        ident_reg <= pair_cnt_reg;
                        idx_reg   <= '0;
                        col_reg   <= lm1;
                    end
                    else
                    begin
                        total_reg <= total_reg + {7'd0, pair_cnt_reg};
                        if (pb_valid_reg)
                        begin
                            last_lo_reg <= pb_i_reg;
                            last_hi_reg <= pb_j_reg;
                        end
                    end
                end
                S_K_MUL:
                begin
                    if (mm_done)
                    begin
                        if (last_j)
                        begin
                            rec_reg      <= 1'b1;
                            i_reg        <= '0;
                            idx_reg      <= IDX_W'(1);
                            pair_cnt_reg <= '0;
                            pb_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                S_W_MUL:
                begin
                    if (mm_done && (col_reg != '0))
                    begin
                        col_reg <= col_reg - COL_W'(1);
                        idx_reg <= '0;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        total_reg     <= '0;
                        ident_reg     <= '0;
                        last_lo_reg   <= '0;
                        last_hi_reg   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_H_RD || state_reg == S_LOAD)
        begin
            if (state_reg == S_LOAD)
            begin
                h_reg <= '0;
            end
        end
        if (state_reg == S_H_MUL && mm_done)
        begin
            h_reg <= (col_reg == lm1) ? '0 : mm_res;
        end
        if (state_reg == S_P_END && !rec_reg)
        begin
            w_reg <= HASH_W'(1);
        end
        if (state_reg == S_W_MUL && mm_done)
        begin
            w_reg <= mm_res;
        end
        if (state_reg == S_P_CMP && key_eq && rec_reg && better)
        begin
            pb_key_reg <= key_rd_a;
            pb_i_reg   <= i_reg;
            pb_j_reg   <= idx_reg;
        end
        if (state_reg == S_FIN && !out_valid_reg)
        begin
            out_data_reg[0]     <= (total_reg != '0);
            out_data_reg[10:1]  <= (total_reg != '0 && !mode_reg) ? last_lo_reg : '0;
            out_data_reg[20:11] <= (total_reg != '0 && !mode_reg) ? last_hi_reg : '0;
            out_data_reg[39:21] <= (total_reg != '0 && mode_reg) ? sim : '0;
        end
    end

    // character store
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            char_mem[{s_reg, p_reg}] <= s_tdata[6:0];
        end
        char_rd <= char_mem[{idx_reg, col_reg}];
    end

    // hash store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_H_MUL && mm_done && col_reg == lm1)
        begin
            hash_mem[idx_reg] <= mm_res;
        end
        hash_rd <= hash_mem[idx_reg];
    end

    // key store: one write port, two read ports
    assign key_we = mm_done && ((state_reg == S_K_MUL) ||
                    (state_reg == S_H_MUL && col_reg == lm1));

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[idx_reg] <= mm_res;
        end
        key_rd_a <= key_mem[i_reg];
        key_rd_b <= key_mem[idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
